FILE: sv/stereo_level_meter_peak_hold_core_assert.svh
// Assertion macros shared by the stereo level meter RTL.
`ifndef STEREO_LEVEL_METER_PEAK_HOLD_CORE_ASSERT_SVH
`define STEREO_LEVEL_METER_PEAK_HOLD_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stereo level meter assertion failed");

// Next-cycle implication, disabled during reset.
`define SLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stereo level meter assertion failed");

`endif

FILE: sv/slm_pkg.sv
// Package with shared types, constants and helpers of the stereo level meter.
package slm_pkg;

   localparam int FRAC_BITS     = 15;
   localparam int COEF_BITS     = 15;
   localparam int LEVEL_W       = 16;
   localparam int IN_W          = 17;
   localparam int HOLD_W        = 8;
   localparam int SEG_W         = 6;
   localparam int IDX_W         = 7;
   localparam int MAX_SEGMENTS  = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 96;
   localparam int RSP_USED_W    = 4 * LEVEL_W + 4 * SEG_W + 3;

   localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << FRAC_BITS;

   localparam logic [COEF_BITS-1:0] RELEASE_COEF_RESET = COEF_BITS'(30147);
   localparam logic [COEF_BITS-1:0] PEAK_DECAY_RESET   = COEF_BITS'(32113);
   localparam logic [HOLD_W-1:0]    HOLD_TICKS_RESET   = HOLD_W'(45);
   localparam logic [LEVEL_W-1:0]   CLIP_THRESH_RESET  = LEVEL_W'(32113);
   localparam logic [SEG_W-1:0]     SEG_COUNT_RESET    = SEG_W'(25);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RELEASE_COEF    = 3'd0,
      CSR_PEAK_DECAY_COEF = 3'd1,
      CSR_HOLD_TICKS      = 3'd2,
      CSR_CLIP_THRESHOLD  = 3'd3,
      CSR_SEGMENT_COUNT   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic mult;
      logic update;
      logic scale;
   } lane_ctrl_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] release_coef;
      logic [COEF_BITS-1:0] peak_decay_coef;
      logic [HOLD_W-1:0]    hold_ticks;
      logic [SEG_W-1:0]     seg_n;
   } lane_cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
      logic [IDX_W-1:0]   level_idx;
      logic [IDX_W-1:0]   peak_idx;
   } lane_res_type;

   // Effective segment count: zero reads as one, large values saturate.
   function automatic logic [SEG_W-1:0] seg_count_eff(input logic [SEG_W-1:0] raw);
      logic [SEG_W-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = SEG_W'(1);
      end else if (raw > SEG_W'(MAX_SEGMENTS)) begin
         n = SEG_W'(MAX_SEGMENTS);
      end
      return n;
   endfunction

endpackage

FILE: sv/slm_lane.sv
// One channel lane: input clamp, level ballistics, peak hold and bar scaling.
module slm_lane
   import slm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lane_ctrl_type        ctrl,
   input  logic signed [IN_W-1:0] level_in,
   input  lane_cfg_type         cfg,
   output lane_res_type         res
);

   logic [LEVEL_W-1:0]         in_ff, kept_ff, fresh_ff, decayed_ff;
   logic [LEVEL_W-1:0]         level_ff, level_in_next;
   logic [LEVEL_W-1:0]         peak_ff, peak_in;
   logic [HOLD_W-1:0]          hold_ff, hold_in;
   logic [LEVEL_W+SEG_W-1:0]   level_prod_ff, peak_prod_ff;

   logic [LEVEL_W-1:0]         clamped;
   logic [LEVEL_W-1:0]         release_comp;
   logic [2*LEVEL_W-2:0]       kept_prod;
   logic [2*LEVEL_W-1:0]       fresh_prod;
   logic [2*LEVEL_W-2:0]       decay_prod;

   always_comb begin
      if (level_in[IN_W-1]) begin
         clamped = '0;
      end else if (level_in[LEVEL_W-1:0] > ONE_LEVEL) begin
         clamped = ONE_LEVEL;
      end else begin
         clamped = level_in[LEVEL_W-1:0];
      end
      release_comp = ONE_LEVEL - LEVEL_W'(cfg.release_coef);
      kept_prod    = (2*LEVEL_W-1)'(level_ff) * (2*LEVEL_W-1)'(cfg.release_coef);
      fresh_prod   = (2*LEVEL_W)'(clamped) * (2*LEVEL_W)'(release_comp);
      decay_prod   = (2*LEVEL_W-1)'(peak_ff) * (2*LEVEL_W-1)'(cfg.peak_decay_coef);
   end

   always_comb begin
      if (in_ff > level_ff) begin
         level_in_next = in_ff;
      end else begin
         level_in_next = kept_ff + fresh_ff;
      end
      peak_in = peak_ff;
      hold_in = hold_ff;
      if (level_in_next > peak_ff) begin
         peak_in = level_in_next;
         hold_in = cfg.hold_ticks;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - HOLD_W'(1);
      end else begin
         peak_in = decayed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mult) begin
         in_ff      <= clamped;
         kept_ff    <= kept_prod[COEF_BITS +: LEVEL_W];
         fresh_ff   <= fresh_prod[COEF_BITS +: LEVEL_W];
         decayed_ff <= decay_prod[COEF_BITS +: LEVEL_W];
      end
      if (ctrl.scale) begin
         level_prod_ff <= (LEVEL_W+SEG_W)'(level_ff) * (LEVEL_W+SEG_W)'(cfg.seg_n);
         peak_prod_ff  <= (LEVEL_W+SEG_W)'(peak_ff) * (LEVEL_W+SEG_W)'(cfg.seg_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         peak_ff  <= '0;
         hold_ff  <= '0;
      end else if (ctrl.update) begin
         level_ff <= level_in_next;
         peak_ff  <= peak_in;
         hold_ff  <= hold_in;
      end
   end

   assign res.level     = level_ff;
   assign res.peak      = peak_ff;
   assign res.level_idx = level_prod_ff[FRAC_BITS +: IDX_W];
   assign res.peak_idx  = peak_prod_ff[FRAC_BITS +: IDX_W];

endmodule

FILE: sv/slm_merge.sv
// Merging stage: bar figures of both lanes, the shared clip flag and result packing.
module slm_merge
   import slm_pkg::*;
(
   input  lane_res_type           left,
   input  lane_res_type           right,
   input  logic [SEG_W-1:0]       seg_n,
   input  logic [LEVEL_W-1:0]     clip_threshold,
   output logic [RSP_DATA_W-1:0]  rsp_data
);

   logic [IDX_W-1:0] n_wide, lit_l_raw, lit_r_raw;
   logic [SEG_W-1:0] lit_l, lit_r;
   logic             shown_l, shown_r, clipping;

   always_comb begin
      n_wide    = IDX_W'(seg_n);
      lit_l_raw = left.level_idx + IDX_W'(1);
      lit_r_raw = right.level_idx + IDX_W'(1);
      lit_l     = (lit_l_raw > n_wide) ? seg_n : lit_l_raw[SEG_W-1:0];
      lit_r     = (lit_r_raw > n_wide) ? seg_n : lit_r_raw[SEG_W-1:0];
      shown_l   = (left.peak != '0) && (left.peak_idx < n_wide);
      shown_r   = (right.peak != '0) && (right.peak_idx < n_wide);
      clipping  = (left.peak >= clip_threshold) || (right.peak >= clip_threshold);
      rsp_data  = {(RSP_DATA_W-RSP_USED_W)'(0), clipping, shown_r, shown_l,
                   right.peak_idx[SEG_W-1:0], left.peak_idx[SEG_W-1:0],
                   lit_r, lit_l, right.peak, left.peak, right.level, left.level};
   end

endmodule

FILE: sv/stereo_level_meter_peak_hold_core.sv
// Top level of the stereo level meter with peak hold ballistics.
// Usage:
// The req_ channel carries one meter tick per transaction: left and right raw
// levels in Q2.15 two's complement. The rsp_ channel returns one transaction per
// tick with smoothed levels, held peaks, lit bar segments, peak segments, peak
// visibility flags and the clip flag.
// The csr_ channel writes one configuration register per transaction; it is
// always ready and should only be used while no tick is in flight.
// The ballistics multiplies are registered at the accepting edge; the level and
// peak update, the bar scaling multiplies and the merge into the output register
// follow in that order. The left and right lanes run side by side; the shared
// sequencer accepts a new tick only once the previous one has been merged into
// the output register.
// Reset clears levels, peaks and hold counters to zero, loads the register
// defaults and empties the result register.
// When the receiver stalls, the result stays in the output register and the next
// tick waits in its final step until the register is free.
module stereo_level_meter_peak_hold_core
   import slm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // left_in [16:0], right_in [33:17]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // left_level [15:0], right_level [31:16], left_peak [47:32],
   // right_peak [63:48], left_lit [69:64], right_lit [75:70],
   // left_peak_segment [81:76], right_peak_segment [87:82],
   // left_peak_shown [88], right_peak_shown [89], clipping [90]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   `include "stereo_level_meter_peak_hold_core_assert.svh"

   state_type               state_ff, state_in;
   logic [COEF_BITS-1:0]    release_coef_ff, peak_decay_coef_ff;
   logic [HOLD_W-1:0]       hold_ticks_ff;
   logic [LEVEL_W-1:0]      clip_threshold_ff;
   logic [SEG_W-1:0]        segment_count_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, merged;
   logic                    out_load;
   lane_ctrl_type           ctrl;
   lane_cfg_type            lane_cfg;
   lane_res_type            res_left, res_right;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_coef_ff    <= RELEASE_COEF_RESET;
         peak_decay_coef_ff <= PEAK_DECAY_RESET;
         hold_ticks_ff      <= HOLD_TICKS_RESET;
         clip_threshold_ff  <= CLIP_THRESH_RESET;
         segment_count_ff   <= SEG_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RELEASE_COEF:    release_coef_ff    <= csr_data[COEF_BITS-1:0];
            CSR_PEAK_DECAY_COEF: peak_decay_coef_ff <= csr_data[COEF_BITS-1:0];
            CSR_HOLD_TICKS:      hold_ticks_ff      <= csr_data[HOLD_W-1:0];
            CSR_CLIP_THRESHOLD:  clip_threshold_ff  <= csr_data[LEVEL_W-1:0];
            CSR_SEGMENT_COUNT:   segment_count_ff   <= csr_data[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   assign lane_cfg.release_coef    = release_coef_ff;
   assign lane_cfg.peak_decay_coef = peak_decay_coef_ff;
   assign lane_cfg.hold_ticks      = hold_ticks_ff;
   assign lane_cfg.seg_n           = seg_count_eff(segment_count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_EMIT;
         ST_EMIT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      ctrl        = '0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.mult  = req_tvalid;
         end
         ST_UPDATE: ctrl.update = 1'b1;
         ST_SCALE:  ctrl.scale  = 1'b1;
         ST_EMIT:   out_load    = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= merged;
      end
   end

   slm_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .level_in (req_tdata[IN_W-1:0]),
      .cfg      (lane_cfg),
      .res      (res_left)
   );

   slm_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .level_in (req_tdata[2*IN_W-1:IN_W]),
      .cfg      (lane_cfg),
      .res      (res_right)
   );

   slm_merge u_merge (
      .left           (res_left),
      .right          (res_right),
      .seg_n          (lane_cfg.seg_n),
      .clip_threshold (clip_threshold_ff),
      .rsp_data       (merged)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SLM_ASSERT_NEXT(a_accept_starts_update, clock, reset, req_tvalid && req_tready,
      state_ff == ST_UPDATE)
   `SLM_ASSERT_SAME(a_result_from_emit, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_EMIT)
   `SLM_ASSERT_SAME(a_lit_nonzero, clock, reset, rsp_valid_ff,
      (rsp_data_ff[69:64] != '0) && (rsp_data_ff[75:70] != '0))
   `SLM_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != ST_IDLE,
      !ctrl.mult)

endmodule

FILE: tb/stereo_level_meter_peak_hold_core_tb.sv
// Self-checking testbench for the stereo level meter core with peak hold ballistics.
module stereo_level_meter_peak_hold_core_tb;
   import slm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;
   localparam int DIRECTED_COUNT = 18;
   localparam int DIRECTED_L[DIRECTED_COUNT] = '{0, 32768, 0, 65535, -65536, -1, 32769, 32767,
      16384, 0, 0, 0, 1, 100, 32768, -1, 8000, 0};
   localparam int DIRECTED_R[DIRECTED_COUNT] = '{0, 0, 32768, -65536, 65535, 32769, -1, 1,
      16384, 0, 0, 0, 32767, 200, 32768, -1, 24000, 0};

   typedef struct {
      logic [LEVEL_W-1:0] level_l;
      logic [LEVEL_W-1:0] level_r;
      logic [LEVEL_W-1:0] peak_l;
      logic [LEVEL_W-1:0] peak_r;
      logic [SEG_W-1:0]   lit_l;
      logic [SEG_W-1:0]   lit_r;
      logic [SEG_W-1:0]   seg_l;
      logic [SEG_W-1:0]   seg_r;
      logic               shown_l;
      logic               shown_r;
      logic               clip;
   } meter_frame_type;

   class meter_checker;
      logic [COEF_BITS-1:0] release_coef;
      logic [COEF_BITS-1:0] decay_coef;
      logic [HOLD_W-1:0]    hold_reload;
      logic [LEVEL_W-1:0]   clip_level;
      logic [SEG_W-1:0]     seg_setting;
      logic [LEVEL_W-1:0]   level[2];
      logic [LEVEL_W-1:0]   peak[2];
      logic [HOLD_W-1:0]    hold[2];
      meter_frame_type      expected_frames[$];
      int                   errors;
      int                   frames_seen;

      function new();
         release_coef = RELEASE_COEF_RESET;
         decay_coef   = PEAK_DECAY_RESET;
         hold_reload  = HOLD_TICKS_RESET;
         clip_level   = CLIP_THRESH_RESET;
         seg_setting  = SEG_COUNT_RESET;
         for (int ch = 0; ch < 2; ch++) begin
            level[ch] = '0;
            peak[ch]  = '0;
            hold[ch]  = '0;
         end
         errors = 0;
         frames_seen = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_RELEASE_COEF:    release_coef = value[COEF_BITS-1:0];
            CSR_PEAK_DECAY_COEF: decay_coef   = value[COEF_BITS-1:0];
            CSR_HOLD_TICKS:      hold_reload  = value[HOLD_W-1:0];
            CSR_CLIP_THRESHOLD:  clip_level   = value[LEVEL_W-1:0];
            CSR_SEGMENT_COUNT:   seg_setting  = value[SEG_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [LEVEL_W-1:0] clamp(logic [IN_W-1:0] raw);
         if (raw[IN_W-1]) return '0;
         if (raw > IN_W'(ONE_LEVEL)) return ONE_LEVEL;
         return raw[LEVEL_W-1:0];
      endfunction

      function void advance_channel(int ch, logic [LEVEL_W-1:0] sample);
         logic [31:0] kept;
         logic [31:0] fresh;
         if (sample > level[ch]) begin
            level[ch] = sample;
         end else begin
            kept  = (32'(level[ch]) * 32'(release_coef)) >> COEF_BITS;
            fresh = (32'(sample) * ((32'(1) << COEF_BITS) - 32'(release_coef))) >> COEF_BITS;
            level[ch] = LEVEL_W'(kept + fresh);
         end
         if (level[ch] > peak[ch]) begin
            peak[ch] = level[ch];
            hold[ch] = hold_reload;
         end else if (hold[ch] != '0) begin
            hold[ch] = hold[ch] - 1'b1;
         end else begin
            peak[ch] = LEVEL_W'((32'(peak[ch]) * 32'(decay_coef)) >> COEF_BITS);
         end
      endfunction

      function logic [IDX_W-1:0] bar_index(logic [LEVEL_W-1:0] value, logic [SEG_W-1:0] n);
         return IDX_W'((32'(value) * 32'(n)) >> FRAC_BITS);
      endfunction

      function void note_tick(logic [IN_W-1:0] left_raw, logic [IN_W-1:0] right_raw);
         meter_frame_type  f;
         logic [SEG_W-1:0] n;
         logic [IDX_W-1:0] lit_l;
         logic [IDX_W-1:0] lit_r;
         logic [IDX_W-1:0] seg_l;
         logic [IDX_W-1:0] seg_r;
         advance_channel(0, clamp(left_raw));
         advance_channel(1, clamp(right_raw));
         n = seg_setting;
         if (n == '0) n = SEG_W'(1);
         else if (n > SEG_W'(MAX_SEGMENTS)) n = SEG_W'(MAX_SEGMENTS);
         lit_l = bar_index(level[0], n) + 1'b1;
         lit_r = bar_index(level[1], n) + 1'b1;
         if (lit_l > IDX_W'(n)) lit_l = IDX_W'(n);
         if (lit_r > IDX_W'(n)) lit_r = IDX_W'(n);
         seg_l = bar_index(peak[0], n);
         seg_r = bar_index(peak[1], n);
         f.level_l = level[0];
         f.level_r = level[1];
         f.peak_l  = peak[0];
         f.peak_r  = peak[1];
         f.lit_l   = lit_l[SEG_W-1:0];
         f.lit_r   = lit_r[SEG_W-1:0];
         f.seg_l   = seg_l[SEG_W-1:0];
         f.seg_r   = seg_r[SEG_W-1:0];
         f.shown_l = (peak[0] != '0) && (seg_l < IDX_W'(n));
         f.shown_r = (peak[1] != '0) && (seg_r < IDX_W'(n));
         f.clip    = (peak[0] >= clip_level) || (peak[1] >= clip_level);
         expected_frames.push_back(f);
      endfunction

      function int outstanding();
         return expected_frames.size();
      endfunction

      task report(string msg);
         $display("result %0d: %s", frames_seen, msg);
         errors++;
      endtask

      task compare_field(string name, logic [LEVEL_W-1:0] got, logic [LEVEL_W-1:0] want);
         if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_frame(logic [RSP_DATA_W-1:0] data);
         meter_frame_type want;
         if (expected_frames.size() == 0) begin
            report("result arrived with no tick outstanding");
         end else begin
            want = expected_frames.pop_front();
            compare_field("left_level", data[15:0], want.level_l);
            compare_field("right_level", data[31:16], want.level_r);
            compare_field("left_peak", data[47:32], want.peak_l);
            compare_field("right_peak", data[63:48], want.peak_r);
            compare_field("left_lit", data[69:64], want.lit_l);
            compare_field("right_lit", data[75:70], want.lit_r);
            compare_field("left_peak_segment", data[81:76], want.seg_l);
            compare_field("right_peak_segment", data[87:82], want.seg_r);
            compare_field("left_peak_shown", data[88], want.shown_l);
            compare_field("right_peak_shown", data[89], want.shown_r);
            compare_field("clipping", data[90], want.clip);
         end
         frames_seen++;
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   meter_checker sb = new();
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit quiet = 1'b0;
   int hold_off_cycles = 0;

   stereo_level_meter_peak_hold_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.write_register(index, value);
   endtask

   task automatic send_tick(input logic [IN_W-1:0] left_raw, input logic [IN_W-1:0] right_raw);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({right_raw, left_raw});
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_tick(left_raw, right_raw);
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [IN_W-1:0] draw_level();
      if (quiet && $urandom_range(0, 3) != 0) return '0;
      case ($urandom_range(0, 9))
         0: return IN_W'($urandom);
         1, 2: return '0;
         3: return IN_W'($urandom_range(32760, 32768));
         default: return IN_W'($urandom_range(0, 32768) >> $urandom_range(0, 6));
      endcase
   endfunction

   task automatic run_ticks(input int count);
      for (int i = 0; i < count; i++) send_tick(draw_level(), draw_level());
   endtask

   function automatic logic [CSR_DATA_W-1:0] draw_coef();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         default: return CSR_DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = rx_steady ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) @(posedge clock);
         sb.check_frame(rsp_tdata);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_tick(IN_W'(DIRECTED_L[i]), IN_W'(DIRECTED_R[i]));
      end
      finish_phase();

      write_register(CSR_RELEASE_COEF, '0);
      write_register(CSR_PEAK_DECAY_COEF, '0);
      write_register(CSR_HOLD_TICKS, '0);
      write_register(CSR_CLIP_THRESHOLD, '0);
      write_register(CSR_SEGMENT_COUNT, '0);
      write_register(CSR_NO_REGISTER, 16'hFFFF);
      csr_valid <= 1'b0;
      run_ticks(60);
      finish_phase();

      write_register(CSR_RELEASE_COEF, 16'h7FFF);
      write_register(CSR_PEAK_DECAY_COEF, 16'h7FFF);
      write_register(CSR_HOLD_TICKS, 16'd255);
      write_register(CSR_CLIP_THRESHOLD, 16'hFFFF);
      write_register(CSR_SEGMENT_COUNT, 16'd63);
      csr_valid <= 1'b0;
      run_ticks(60);
      finish_phase();

      for (int p = 0; p < 10; p++) begin
         write_register(CSR_RELEASE_COEF, draw_coef());
         write_register(CSR_PEAK_DECAY_COEF, draw_coef());
         case ($urandom_range(0, 3))
            0: write_register(CSR_HOLD_TICKS, '0);
            1: write_register(CSR_HOLD_TICKS, 16'd255);
            2: write_register(CSR_HOLD_TICKS, CSR_DATA_W'($urandom_range(0, 65535)));
            default: write_register(CSR_HOLD_TICKS, CSR_DATA_W'($urandom_range(0, 8)));
         endcase
         case ($urandom_range(0, 4))
            0: write_register(CSR_CLIP_THRESHOLD, '0);
            1: write_register(CSR_CLIP_THRESHOLD, CSR_DATA_W'(ONE_LEVEL));
            2: write_register(CSR_CLIP_THRESHOLD, CSR_DATA_W'($urandom_range(32769, 65535)));
            default: write_register(CSR_CLIP_THRESHOLD, CSR_DATA_W'($urandom_range(0, 32768)));
         endcase
         case ($urandom_range(0, 5))
            0: write_register(CSR_SEGMENT_COUNT, '0);
            1: write_register(CSR_SEGMENT_COUNT, 16'd1);
            2: write_register(CSR_SEGMENT_COUNT, 16'd32);
            3: write_register(CSR_SEGMENT_COUNT, CSR_DATA_W'($urandom_range(33, 63)));
            4: write_register(CSR_SEGMENT_COUNT, CSR_DATA_W'($urandom_range(0, 65535)));
            default: write_register(CSR_SEGMENT_COUNT, CSR_DATA_W'($urandom_range(1, 32)));
         endcase
         if ($urandom_range(0, 2) == 0) write_register(CSR_NO_REGISTER, CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         quiet = ($urandom_range(0, 2) == 0);
         if (p == 0) begin
            tx_steady = 1'b1;
            hold_off_cycles = 300;
         end
         run_ticks(100);
         finish_phase();
      end

      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
